[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL of the color scanline pixel generator.
// Used by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CSP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define CSP_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("assertion failed");
`else
`define CSP_ASSERT(lbl, prop)
`define CSP_ASSERT_RST(lbl, prop)
`endif
`endif

[hw/rtl/csp_pkg.sv]
// Types, constants and code tables of the color scanline pixel generator.
// No dependencies.
package csp_pkg;

  localparam int unsigned CodeW   = 5;
  localparam int unsigned CodesW  = 40;
  localparam int unsigned LineW   = 9;

  localparam logic [LineW-1:0] FrameLines = 9'd262;
  localparam logic [LineW-1:0] FirstShown = 9'd10;
  localparam logic [LineW-1:0] VisStart   = 9'd80;
  localparam logic [LineW-1:0] VisEnd     = 9'd208;
  localparam logic [LineW-1:0] LineReset  = 9'h1FF;

  localparam logic [15:0] HighWinMask = 16'h01FF;
  localparam logic [15:0] HighWinBase = 16'h8000;
  localparam logic [15:0] MaskReset   = 16'h0FFF;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_COLOR_WR = 2'd1,
    CMD_BG_RESET = 2'd2,
    CMD_BG_STEP  = 2'd3
  } cmd_e;

  typedef enum logic {
    CFG_HIRES    = 1'b0,
    CFG_ADDRMASK = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0]        count;
    logic [CodesW-1:0] codes;
    logic [15:0]       faddr;
    logic [15:0]       r0a;
    logic              last;
  } out_word_t;

  function automatic logic [CodeW-1:0] bg_code(input logic [1:0] sel);
    logic [CodeW-1:0] c;
    case (sel)
      2'd0:    c = 5'h02;
      2'd1:    c = 5'h00;
      2'd2:    c = 5'h0c;
      2'd3:    c = 5'h01;
      default: c = 5'h02;
    endcase
    return c;
  endfunction

  function automatic logic [CodeW-1:0] fg_code(input logic [2:0] sel);
    logic [CodeW-1:0] c;
    case (sel)
      3'd0:    c = 5'h00;
      3'd1:    c = 5'h09;
      3'd2:    c = 5'h0a;
      3'd3:    c = 5'h0b;
      3'd4:    c = 5'h14;
      3'd5:    c = 5'h15;
      3'd6:    c = 5'h16;
      3'd7:    c = 5'h17;
      default: c = 5'h00;
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/csp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module csp_ram #(
  parameter int unsigned Width = 3,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/color_scanline_pixel_generator.sv]
// Top level of the color scanline pixel generator.
// Depends on csp_pkg, csp_ram and assert_macros.svh.
//
// Input channel (in_valid_i/in_ready_o) takes one command word. Color store
// writes and background commands take effect at acceptance and give no output.
// A line tick advances the line counter; silent lines give no output, every
// other line gives ten output words (out_valid_o/out_ready_i): one background
// word, eight words of eight pixel codes, one background word with
// line_last_o set.
// Timing: an emitting tick keeps the input not ready until its last word is
// loaded (one output word per cycle while the receiver takes them); the first
// word is loaded from the emit state that acceptance enters. Other commands
// leave the input ready. The rate is set by the slot sequencer, which loads the
// output register once per cycle and fetches the next color store entry
// through the single RAM read port in the same cycle.
// When the receiver stalls, the sequencer holds and the output word holds.
// Reset: line counter all ones, cursor and background select zero, color
// store reads as zero (per-entry valid bits cleared), hires off, address
// mask 0x0FFF.
`include "assert_macros.svh"
module color_scanline_pixel_generator #(
  parameter int unsigned COLOR_STORE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] r0_value_i,
  input  logic        high_window_i,
  input  logic [31:0] display_bytes_low_i,
  input  logic [31:0] display_bytes_high_i,
  input  logic [7:0]  color_index_i,
  input  logic [2:0]  color_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  word_count_o,
  output logic [39:0] pixel_codes_o,
  output logic [15:0] fetch_address_o,
  output logic [15:0] r0_after_o,
  output logic        line_last_o
);
  import csp_pkg::*;

  localparam int unsigned IdxW = $clog2(COLOR_STORE_DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e                 state_q, state_d;
  logic [3:0]             slot_q, slot_d;
  logic [LineW-1:0]       line_q, line_d;
  logic [LineW-1:0]       cursor_q, cursor_d;
  logic [1:0]             bgsel_q, bgsel_d;
  logic                   hires_q;
  logic [15:0]            mask_q;
  logic [COLOR_STORE_DEPTH-1:0] valid_q;
  logic                   visible_q, visible_d;
  logic [63:0]            bytes_q, bytes_d;
  logic [15:0]            faddr_q, faddr_d;
  logic [15:0]            r0a_q, r0a_d;
  logic                   out_valid_q, out_valid_d;
  out_word_t              out_q, out_d;

  logic                   accept;
  logic                   store_we;
  logic [2:0]             ram_rdata;
  logic                   load;
  logic [LineW-1:0]       line_inc;
  logic [LineW-1:0]       line_nxt;
  logic                   vis_new;
  logic [CodeW-1:0]       bg, fg;
  logic [7:0]             cur_byte;
  logic [CodesW-1:0]      byte_codes;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign store_we   = accept && (cmd_e'(cmd_i) == CMD_COLOR_WR);
  assign load       = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign line_inc   = line_q + 9'd1;
  assign line_nxt   = line_q + 9'd1;
  assign vis_new    = (line_inc >= VisStart) && (line_inc < VisEnd);
  assign bg         = bg_code(bgsel_q);
  assign fg         = visible_q ? fg_code(valid_q[cursor_q[IdxW-1:0]] ? ram_rdata : 3'd0) : bg;
  assign cur_byte   = visible_q ? bytes_q[7:0] : 8'd0;

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      byte_codes[CodeW*j +: CodeW] = cur_byte[7-j] ? fg : bg;
    end
  end

  csp_ram #(
    .Width(3),
    .Depth(COLOR_STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (store_we),
    .waddr_i(color_index_i[IdxW-1:0]),
    .wdata_i(color_value_i),
    .raddr_i(cursor_d[IdxW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    line_d      = line_q;
    cursor_d    = cursor_q;
    bgsel_d     = bgsel_q;
    visible_d   = visible_q;
    bytes_d     = bytes_q;
    faddr_d     = faddr_q;
    r0a_d       = r0a_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    if (accept) begin
      case (cmd_e'(cmd_i))
        CMD_BG_RESET: bgsel_d = 2'd0;
        CMD_BG_STEP:  bgsel_d = bgsel_q + 2'd1;
        CMD_TICK: begin
          line_d = line_inc;
          if (line_inc >= FirstShown) begin
            if (line_inc == FrameLines) begin
              line_d   = '0;
              cursor_d = '0;
            end
            state_d   = ST_EMIT;
            slot_d    = 4'd0;
            visible_d = vis_new;
            bytes_d   = {display_bytes_high_i, display_bytes_low_i};
            faddr_d   = 16'd0;
            r0a_d     = r0_value_i;
            if (vis_new) begin
              faddr_d = (high_window_i || r0_value_i[15]) ?
                        ((r0_value_i & HighWinMask) | HighWinBase) :
                        (r0_value_i & mask_q);
              r0a_d   = r0_value_i + 16'd8;
            end
          end
        end
        default: ;
      endcase
    end

    if (load) begin
      out_valid_d = 1'b1;
      out_d.faddr = faddr_q;
      out_d.r0a   = r0a_q;
      out_d.count = 4'd1;
      out_d.codes = {{(CodesW-CodeW){1'b0}}, bg};
      out_d.last  = 1'b0;
      slot_d      = slot_q + 4'd1;
      if (slot_q == 4'd9) begin
        out_d.last = 1'b1;
        state_d    = ST_IDLE;
        slot_d     = 4'd0;
        if (visible_q) begin
          if (hires_q) begin
            if (line_nxt[1:0] != 2'd0) begin
              cursor_d = cursor_q - 9'd8;
            end
          end else if (line_nxt[3:0] != 4'd0) begin
            cursor_d = cursor_q - 9'd8;
          end else begin
            cursor_d = cursor_q + 9'd24;
          end
        end
      end else if (slot_q != 4'd0) begin
        out_d.count = 4'd8;
        out_d.codes = byte_codes;
        bytes_d     = {8'd0, bytes_q[63:8]};
        if (visible_q) begin
          cursor_d = cursor_q + 9'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= 4'd0;
      line_q      <= LineReset;
      cursor_q    <= '0;
      bgsel_q     <= 2'd0;
      hires_q     <= 1'b0;
      mask_q      <= MaskReset;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      visible_q   <= 1'b0;
      bytes_q     <= '0;
      faddr_q     <= '0;
      r0a_q       <= '0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      line_q      <= line_d;
      cursor_q    <= cursor_d;
      bgsel_q     <= bgsel_d;
      out_valid_q <= out_valid_d;
      visible_q   <= visible_d;
      bytes_q     <= bytes_d;
      faddr_q     <= faddr_d;
      r0a_q       <= r0a_d;
      out_q       <= out_d;
      if (store_we) begin
        valid_q[color_index_i[IdxW-1:0]] <= 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_HIRES:    hires_q <= cfg_data_i[0];
          CFG_ADDRMASK: mask_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign word_count_o    = out_q.count;
  assign pixel_codes_o   = out_q.codes;
  assign fetch_address_o = out_q.faddr;
  assign r0_after_o      = out_q.r0a;
  assign line_last_o     = out_q.last;

  `CSP_ASSERT(a_last_single, (out_valid_o && line_last_o) |-> (word_count_o == 4'd1))
  `CSP_ASSERT(a_short_zero, (out_valid_o && word_count_o != 4'd8) |-> (pixel_codes_o[39:5] == '0))
  `CSP_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(pixel_codes_o)))
  `CSP_ASSERT_RST(a_idle_slot, (state_q == ST_IDLE) |-> (slot_q == 4'd0))

endmodule

[dv/tb_color_scanline_pixel_generator.sv]
// Testbench for color_scanline_pixel_generator: random and directed command words,
// checked word by word against a scoreboard that predicts each scanline.
// Depends on csp_pkg and the RTL of the block.
module tb_color_scanline_pixel_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import csp_pkg::*;

  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned SettleWait  = 16;
  localparam int unsigned RandomWords = 110;

  class pixel_line_scoreboard;
    bit          hires;
    logic [15:0] addr_mask;
    logic [8:0]  line_num;
    logic [8:0]  cursor;
    logic [1:0]  bg_sel;
    logic [2:0]  palette [256];
    out_word_t   pending_words [$];
    int unsigned failures;

    function new();
      hires     = 1'b0;
      addr_mask = MaskReset;
      line_num  = LineReset;
      cursor    = '0;
      bg_sel    = '0;
      failures  = 0;
      foreach (palette[i]) palette[i] = '0;
    endfunction

    function void set_registers(bit hires_val, logic [15:0] mask_val);
      hires     = hires_val;
      addr_mask = mask_val;
    endfunction

    function int unsigned outstanding();
      return pending_words.size();
    endfunction

    function logic [4:0] background_code(logic [1:0] sel);
      case (sel)
        2'd0:    return 5'h02;
        2'd1:    return 5'h00;
        2'd2:    return 5'h0c;
        default: return 5'h01;
      endcase
    endfunction

    function logic [4:0] foreground_code(logic [2:0] sel);
      case (sel)
        3'd0:    return 5'h00;
        3'd1:    return 5'h09;
        3'd2:    return 5'h0a;
        3'd3:    return 5'h0b;
        3'd4:    return 5'h14;
        3'd5:    return 5'h15;
        3'd6:    return 5'h16;
        default: return 5'h17;
      endcase
    endfunction

    function void queue_word(logic [3:0] count, logic [39:0] codes, logic [15:0] faddr,
                             logic [15:0] r0a, logic last);
      out_word_t w;
      w.count = count;
      w.codes = codes;
      w.faddr = faddr;
      w.r0a   = r0a;
      w.last  = last;
      pending_words.push_back(w);
    endfunction

    // Predicts the words of one accepted command and advances the line state.
    function void accept_command(cmd_e cmd, logic [15:0] r0, logic hw, logic [63:0] bytes,
                                 logic [7:0] idx, logic [2:0] val);
      logic [4:0]  bg;
      logic [4:0]  fg;
      logic [7:0]  bits;
      logic [39:0] codes;
      logic [15:0] faddr;
      logic [15:0] r0a;
      logic [8:0]  nxt;
      bit          visible;
      case (cmd)
        CMD_COLOR_WR: palette[idx] = val;
        CMD_BG_RESET: bg_sel = '0;
        CMD_BG_STEP:  bg_sel = bg_sel + 2'd1;
        default: begin
          line_num = line_num + 9'd1;
          if (line_num < FirstShown) return;
          if (line_num == FrameLines) begin
            line_num = '0;
            cursor   = '0;
          end
          bg      = background_code(bg_sel);
          visible = (line_num >= VisStart) && (line_num < VisEnd);
          faddr   = '0;
          r0a     = r0;
          if (visible) begin
            faddr = (hw || r0[15]) ? ((r0 & HighWinMask) | HighWinBase) : (r0 & addr_mask);
            r0a   = r0 + 16'd8;
          end
          queue_word(4'd1, 40'(bg), faddr, r0a, 1'b0);
          for (int i = 0; i < 8; i++) begin
            bits = visible ? bytes[8*i +: 8] : 8'h00;
            fg   = bg;
            if (visible) begin
              fg     = foreground_code(palette[cursor[7:0]]);
              cursor = cursor + 9'd1;
            end
            codes = '0;
            for (int j = 0; j < 8; j++) codes[5*j +: 5] = bits[7-j] ? fg : bg;
            queue_word(4'd8, codes, faddr, r0a, 1'b0);
          end
          queue_word(4'd1, 40'(bg), faddr, r0a, 1'b1);
          if (visible) begin
            nxt = line_num + 9'd1;
            if (hires) begin
              if (nxt[1:0] != 2'd0) cursor = cursor - 9'd8;
            end else if (nxt[3:0] != 4'd0) begin
              cursor = cursor - 9'd8;
            end else begin
              cursor = cursor + 9'd24;
            end
          end
        end
      endcase
    endfunction

    function void check_word(logic [3:0] count, logic [39:0] codes, logic [15:0] faddr,
                             logic [15:0] r0a, logic last);
      out_word_t e;
      if (pending_words.size() == 0) begin
        $error("unexpected word: count %0d codes %h", count, codes);
        failures++;
        return;
      end
      e = pending_words.pop_front();
      if (count !== e.count) begin
        $error("word_count: expected %0d, actual %0d", e.count, count);
        failures++;
      end
      if (codes !== e.codes) begin
        $error("pixel_codes: expected %h, actual %h", e.codes, codes);
        failures++;
      end
      if (faddr !== e.faddr) begin
        $error("fetch_address: expected %h, actual %h", e.faddr, faddr);
        failures++;
      end
      if (r0a !== e.r0a) begin
        $error("r0_after: expected %h, actual %h", e.r0a, r0a);
        failures++;
      end
      if (last !== e.last) begin
        $error("line_last: expected %0b, actual %0b", e.last, last);
        failures++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i = '0;
  logic [15:0] r0_value_i = '0;
  logic        high_window_i = 1'b0;
  logic [31:0] display_bytes_low_i = '0;
  logic [31:0] display_bytes_high_i = '0;
  logic [7:0]  color_index_i = '0;
  logic [2:0]  color_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  word_count_o;
  logic [39:0] pixel_codes_o;
  logic [15:0] fetch_address_o;
  logic [15:0] r0_after_o;
  logic        line_last_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles = 0;

  pixel_line_scoreboard board = new();

  color_scanline_pixel_generator u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .cmd_i               (cmd_i),
    .r0_value_i          (r0_value_i),
    .high_window_i       (high_window_i),
    .display_bytes_low_i (display_bytes_low_i),
    .display_bytes_high_i(display_bytes_high_i),
    .color_index_i       (color_index_i),
    .color_value_i       (color_value_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .word_count_o        (word_count_o),
    .pixel_codes_o       (pixel_codes_o),
    .fetch_address_o     (fetch_address_o),
    .r0_after_o          (r0_after_o),
    .line_last_o         (line_last_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_word(word_count_o, pixel_codes_o, fetch_address_o, r0_after_o, line_last_o);
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("color_scanline_pixel_generator: mismatch");
      $finish;
    end
  end

  function automatic bit sender_idles();
    return $urandom_range(99) < send_idle_pct;
  endfunction

  task automatic program_registers(input bit hires_val, input logic [15:0] mask_val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_HIRES;
    cfg_data_i  <= 16'(hires_val);
    @(posedge clk_i);
    cfg_index_i <= CFG_ADDRMASK;
    cfg_data_i  <= mask_val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    board.set_registers(hires_val, mask_val);
  endtask

  task automatic send_command(input cmd_e cmd, input logic [15:0] r0, input logic hw,
                              input logic [63:0] bytes, input logic [7:0] idx,
                              input logic [2:0] val);
    if (sender_idles()) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (sender_idles());
    end
    in_valid_i           <= 1'b1;
    cmd_i                <= cmd;
    r0_value_i           <= r0;
    high_window_i        <= hw;
    display_bytes_low_i  <= bytes[31:0];
    display_bytes_high_i <= bytes[63:32];
    color_index_i        <= idx;
    color_value_i        <= val;
    do @(posedge clk_i); while (!in_ready_o);
    board.accept_command(cmd, r0, hw, bytes, idx, val);
  endtask

  task automatic send_random_command();
    int unsigned pick;
    cmd_e        cmd;
    logic [7:0]  idx;
    pick = $urandom_range(99);
    if (pick < 78) cmd = CMD_TICK;
    else if (pick < 93) cmd = CMD_COLOR_WR;
    else if (pick < 98) cmd = CMD_BG_STEP;
    else cmd = CMD_BG_RESET;
    // keep half the writes near the rows the cursor walks
    idx = $urandom_range(1) ? 8'($urandom_range(63)) : 8'($urandom);
    send_command(cmd, 16'($urandom), ($urandom_range(3) == 0), {$urandom, $urandom}, idx,
                 3'($urandom));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          program_registers(1'b0, 16'hFFFF);
          send_idle_pct = 22;
          recv_idle_pct = 70;
        end
        1: begin
          program_registers(1'b1, 16'h0000);
          send_idle_pct = 70;
          recv_idle_pct = 22;
        end
        default: begin
          program_registers(1'($urandom), 16'($urandom));
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      if (phase == 0) begin
        send_command(CMD_COLOR_WR, '0, 1'b0, '0, 8'd0, 3'd7);
        send_command(CMD_COLOR_WR, '0, 1'b0, '0, 8'd1, 3'd0);
        send_command(CMD_COLOR_WR, '0, 1'b0, '0, 8'd255, 3'd7);
        send_command(CMD_COLOR_WR, '1, 1'b1, '1, 8'd2, 3'd5);
        // first ticks after reset are silent lines
        for (int i = 0; i < 10; i++) begin
          send_command(CMD_TICK, i[0] ? 16'hFFFF : 16'h0000, i[0], i[0] ? '1 : '0, '0, '0);
        end
        send_command(CMD_TICK, 16'hFFFF, 1'b1, '1, '1, '1);
        for (int i = 0; i < 3; i++) begin
          send_command(CMD_BG_STEP, '0, 1'b0, '0, '0, '0);
          send_command(CMD_TICK, 16'h7FFF, 1'b0, 64'hA5A5_5A5A_FF00_00FF, '0, '0);
        end
        send_command(CMD_BG_STEP, '0, 1'b0, '0, '0, '0);
        send_command(CMD_BG_RESET, '0, 1'b0, '0, '0, '0);
        send_command(CMD_TICK, 16'h8000, 1'b0, 64'h0123_4567_89AB_CDEF, '0, '0);
      end

      repeat (RandomWords) send_random_command();
      settle();
    end

    if (board.failures == 0 && board.outstanding() == 0) begin
      $display("color_scanline_pixel_generator: match");
    end else begin
      $display("color_scanline_pixel_generator: mismatch");
    end
    $finish;
  end

endmodule
